// ----- src/bfl_pkg.sv -----
`default_nettype none
package bfl_pkg;

    // number formats
    localparam int FRAC_BITS   = 16;
    localparam int TRIG_STAGES = 16;
    localparam int DATA_W      = 32;
    localparam int ANGLE_W     = 16;
    localparam int CS_W        = FRAC_BITS + 2;
    localparam int CORD_W      = 34;
    localparam int CORD_FRAC   = 30;
    localparam int PROD_W      = CS_W + DATA_W;
    localparam int GP_W        = 2 * DATA_W + 2;
    localparam int SQ_W        = 2 * DATA_W;
    localparam int HA_W        = PROD_W - FRAC_BITS;
    localparam int NUM_W       = PROD_W;
    localparam int DEN_W       = DATA_W + 1;
    localparam int SAT_W       = 72;
    localparam int STAGE_W     = $clog2(TRIG_STAGES);
    localparam int CFG_IDX_W   = 1;
    localparam int ARITH_STAGES = 8;

    localparam longint CORDIC_X0    = 652032874;
    localparam longint TURN_PER_RAD = 683565276;

    localparam logic [DATA_W-1:0] POSITION_GAIN_RST = DATA_W'(65536);
    localparam logic [DATA_W-1:0] VELOCITY_GAIN_RST = DATA_W'(131072);

    // angle constants in 2^-32 turn
    localparam logic signed [CORD_W-1:0] Z_QUARTER = CORD_W'(64'sd1 <<< 30);
    localparam logic signed [CORD_W-1:0] Z_HALF    = CORD_W'(64'sd1 <<< 31);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION_GAIN = 1'b0,
        REG_VELOCITY_GAIN = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  pos_x;
        logic signed [DATA_W-1:0]  pos_y;
        logic        [ANGLE_W-1:0] heading;
        logic signed [DATA_W-1:0]  speed;
        logic signed [DATA_W-1:0]  target_x;
        logic signed [DATA_W-1:0]  target_y;
        logic signed [DATA_W-1:0]  target_vel_x;
        logic signed [DATA_W-1:0]  target_vel_y;
        logic signed [DATA_W-1:0]  target_acc_x;
        logic signed [DATA_W-1:0]  target_acc_y;
    } feed_t;

    typedef struct packed {
        feed_t                     smp;
        logic signed [CORD_W-1:0]  x;
        logic signed [CORD_W-1:0]  y;
        logic signed [CORD_W-1:0]  z;
        logic                      neg;
    } cord_t;

    typedef struct packed {
        feed_t                     smp;
        logic signed [CS_W-1:0]    c;
        logic signed [CS_W-1:0]    s;
        logic signed [DATA_W-1:0]  ex;
        logic signed [DATA_W-1:0]  ey;
        logic signed [DATA_W-1:0]  dvx;
        logic signed [DATA_W-1:0]  dvy;
        logic signed [DATA_W-1:0]  q;
        logic signed [DATA_W-1:0]  vx;
        logic signed [DATA_W-1:0]  vy;
        logic signed [DATA_W-1:0]  rx;
        logic signed [DATA_W-1:0]  ry;
        logic        [DATA_W-1:0]  mag;
        logic        [SQ_W-1:0]    mm;
        logic signed [PROD_W-1:0]  mc;
        logic signed [PROD_W-1:0]  ms;
        logic signed [PROD_W-1:0]  qc;
        logic signed [PROD_W-1:0]  qs;
        logic signed [PROD_W-1:0]  crx;
        logic signed [PROD_W-1:0]  sry;
        logic signed [PROD_W-1:0]  srx;
        logic signed [PROD_W-1:0]  cry;
        logic signed [GP_W-1:0]    kpex;
        logic signed [GP_W-1:0]    kpey;
        logic signed [GP_W-1:0]    kdx;
        logic signed [GP_W-1:0]    kdy;
        logic signed [HA_W-1:0]    ha;
        logic        [NUM_W-1:0]   num;
        logic                      wneg;
        logic                      zero;
    } work_t;

    typedef struct packed {
        logic signed [HA_W-1:0] ha;
        logic [NUM_W-1:0]       num;
        logic [NUM_W-1:0]       quo;
        logic [DEN_W-1:0]       den;
        logic [DEN_W-1:0]       rem;
        logic                   wneg;
        logic                   zero;
    } div_t;

    typedef logic [CORD_W-1:0] atan_tab_t [TRIG_STAGES];

    // shift-subtract quotient of two non-negative constants
    function automatic longint udiv_calc(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | longint'(1);
            end
        end
        return quo;
    endfunction

    // arctan(2^-i) in 2^-32 turn, from the arctan series
    function automatic longint atan_calc(input int i);
        longint sum;
        longint term;
        int     pw;
        sum = 0;
        if (i == 0)
            return longint'(1) <<< 29;
        for (int k = 0; k <= 40; k++)
        begin
            pw = i * (2 * k + 1);
            if (pw <= 40)
            begin
                term = udiv_calc(longint'(1) <<< (40 - pw), longint'(2 * k + 1));
                sum = ((k & 1) != 0) ? sum - term : sum + term;
            end
        end
        sum = (sum + 128) >>> 8;
        return (sum * TURN_PER_RAD + (longint'(1) <<< 31)) >>> 32;
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t tab;
        for (int i = 0; i < TRIG_STAGES; i++)
        begin
            tab[i] = CORD_W'(atan_calc(i));
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

    // clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - SAT_W'(1);
        if (v > hi)
            return hi[DATA_W-1:0];
        if (v < lo)
            return lo[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [SAT_W-1:0] rnd_q(input logic signed [SAT_W-1:0] v,
                                                      input int sh);
        logic signed [SAT_W-1:0] half;
        half = '0;
        half[sh-1] = 1'b1;
        return (v + half) >>> sh;
    endfunction

endpackage
`default_nettype wire

// ----- src/bfl_if.sv -----
`default_nettype none
interface bfl_feed_if import bfl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  pos_x;
    logic signed [DATA_W-1:0]  pos_y;
    logic        [ANGLE_W-1:0] heading;
    logic signed [DATA_W-1:0]  speed;
    logic signed [DATA_W-1:0]  target_x;
    logic signed [DATA_W-1:0]  target_y;
    logic signed [DATA_W-1:0]  target_vel_x;
    logic signed [DATA_W-1:0]  target_vel_y;
    logic signed [DATA_W-1:0]  target_acc_x;
    logic signed [DATA_W-1:0]  target_acc_y;

    modport source (output valid, pos_x, pos_y, heading, speed, target_x, target_y,
                    target_vel_x, target_vel_y, target_acc_x, target_acc_y,
                    input ready);
    modport sink (input valid, pos_x, pos_y, heading, speed, target_x, target_y,
                  target_vel_x, target_vel_y, target_acc_x, target_acc_y,
                  output ready);
endinterface

interface bfl_thrust_if import bfl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] thrust_one;
    logic signed [DATA_W-1:0] thrust_two;
    logic                     singular;

    modport source (output valid, thrust_one, thrust_two, singular, input ready);
    modport sink (input valid, thrust_one, thrust_two, singular, output ready);
endinterface

interface bfl_cfg_if import bfl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/boat_feedback_linearization.sv -----
// Tracking controller for a two-motor boat. Each feed transaction carries the
// boat state and target; exactly one thrust transaction comes out per feed
// transaction, in order. The block is a pipeline that takes one transaction
// per clock while the output is not stalled: a row of CORDIC cells for
// cos/sin, eight arithmetic stages, one restoring-division cell per quotient
// bit and an output register. A stall at the output holds only the full
// stages; empty stages keep taking transactions. Zero speed gives zero thrusts
// with singular set. Gains are written on the cfg port (index 0 position gain,
// 1 velocity gain) only while no transaction is in flight, a rule for the user
// that the block does not enforce; the port is always ready.
`default_nettype none
module boat_feedback_linearization import bfl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    bfl_feed_if.sink      feed,
    bfl_thrust_if.source  thrust,
    bfl_cfg_if.sink       cfg
);

    logic [DATA_W-1:0] position_gain_reg;
    logic [DATA_W-1:0] velocity_gain_reg;

    cord_t cord_data  [TRIG_STAGES+1];
    logic  cord_valid [TRIG_STAGES+1];
    logic  cord_ready [TRIG_STAGES+1];

    div_t  div_data  [NUM_W+1];
    logic  div_valid [NUM_W+1];
    logic  div_ready [NUM_W+1];

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] thrust_one_reg;
    logic signed [DATA_W-1:0] thrust_two_reg;
    logic                     singular_reg;
    logic signed [DATA_W-1:0] thrust_one_next;
    logic signed [DATA_W-1:0] thrust_two_next;

    // gain registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_gain_reg <= POSITION_GAIN_RST;
            velocity_gain_reg <= VELOCITY_GAIN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_POSITION_GAIN: position_gain_reg <= cfg.data;
                REG_VELOCITY_GAIN: velocity_gain_reg <= cfg.data;
            endcase
        end
    end

    // fold heading into +-quarter turn, seed the rotation
    always_comb
    begin
        logic signed [CORD_W-1:0] z0;
        cord_data[0].smp.pos_x        = feed.pos_x;
        cord_data[0].smp.pos_y        = feed.pos_y;
        cord_data[0].smp.heading      = feed.heading;
        cord_data[0].smp.speed        = feed.speed;
        cord_data[0].smp.target_x     = feed.target_x;
        cord_data[0].smp.target_y     = feed.target_y;
        cord_data[0].smp.target_vel_x = feed.target_vel_x;
        cord_data[0].smp.target_vel_y = feed.target_vel_y;
        cord_data[0].smp.target_acc_x = feed.target_acc_x;
        cord_data[0].smp.target_acc_y = feed.target_acc_y;
        z0 = CORD_W'(signed'({feed.heading, {(DATA_W-ANGLE_W){1'b0}}}));
        cord_data[0].neg = 1'b0;
        if (z0 > Z_QUARTER)
        begin
            z0 = z0 - Z_HALF;
            cord_data[0].neg = 1'b1;
        end
        else if (z0 < -Z_QUARTER)
        begin
            z0 = z0 + Z_HALF;
            cord_data[0].neg = 1'b1;
        end
        cord_data[0].z = z0;
        cord_data[0].x = CORD_W'(CORDIC_X0);
        cord_data[0].y = '0;
    end

    assign cord_valid[0] = feed.valid;
    assign feed.ready    = cord_ready[0];

    // cos/sin cell row
    for (genvar gi = 0; gi < TRIG_STAGES; gi++)
    begin : g_cordic
        bfl_cordic_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .stage      (STAGE_W'(gi)),
            .up_valid   (cord_valid[gi]),
            .up_ready   (cord_ready[gi]),
            .up_data    (cord_data[gi]),
            .down_valid (cord_valid[gi+1]),
            .down_ready (cord_ready[gi+1]),
            .down_data  (cord_data[gi+1])
        );
    end

    // control law arithmetic
    bfl_arith u_arith
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .position_gain (position_gain_reg),
        .velocity_gain (velocity_gain_reg),
        .up_valid      (cord_valid[TRIG_STAGES]),
        .up_ready      (cord_ready[TRIG_STAGES]),
        .up_data       (cord_data[TRIG_STAGES]),
        .down_valid    (div_valid[0]),
        .down_ready    (div_ready[0]),
        .down_data     (div_data[0])
    );

    // division cell row, one quotient bit per cell
    for (genvar gd = 0; gd < NUM_W; gd++)
    begin : g_div
        bfl_div_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (div_valid[gd]),
            .up_ready   (div_ready[gd]),
            .up_data    (div_data[gd]),
            .down_valid (div_valid[gd+1]),
            .down_ready (div_ready[gd+1]),
            .down_data  (div_data[gd+1])
        );
    end

    // combine into the two motor commands
    always_comb
    begin
        logic signed [SAT_W-1:0] w_v;
        w_v = signed'(SAT_W'(div_data[NUM_W].quo));
        if (div_data[NUM_W].wneg)
            w_v = -w_v;
        thrust_one_next = sat32(SAT_W'(div_data[NUM_W].ha) - w_v);
        thrust_two_next = sat32(SAT_W'(div_data[NUM_W].ha) + w_v);
        if (div_data[NUM_W].zero)
        begin
            thrust_one_next = '0;
            thrust_two_next = '0;
        end
    end

    assign div_ready[NUM_W] = !out_valid_reg || thrust.ready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (div_ready[NUM_W])
            out_valid_reg <= div_valid[NUM_W];
    end

    always_ff @(posedge clk)
    begin
        if (div_ready[NUM_W])
        begin
            thrust_one_reg <= thrust_one_next;
            thrust_two_reg <= thrust_two_next;
            singular_reg   <= div_data[NUM_W].zero;
        end
    end

    assign thrust.valid      = out_valid_reg;
    assign thrust.thrust_one = thrust_one_reg;
    assign thrust.thrust_two = thrust_two_reg;
    assign thrust.singular   = singular_reg;

    // singular results carry zero thrust
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && singular_reg) |-> (thrust_one_reg == '0 && thrust_two_reg == '0))
        else $error("singular result with non-zero thrust");

    // a position gain write lands in its register
    a_cfg_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.index == REG_POSITION_GAIN) |=> (position_gain_reg == $past(cfg.data)))
        else $error("position gain write lost");

    // a velocity gain write lands in its register
    a_cfg_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.index == REG_VELOCITY_GAIN) |=> (velocity_gain_reg == $past(cfg.data)))
        else $error("velocity gain write lost");

endmodule
`default_nettype wire

// ----- src/bfl_cordic_cell.sv -----
`default_nettype none
module bfl_cordic_cell import bfl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [STAGE_W-1:0] stage,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire cord_t              up_data,
    output logic                    down_valid,
    input  wire logic               down_ready,
    output cord_t                   down_data
);

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // one micro-rotation towards zero residual angle
    always_comb
    begin
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        logic signed [CORD_W-1:0] a;
        dx = up_data.y >>> stage;
        dy = up_data.x >>> stage;
        a  = signed'(ATAN_TAB[stage]);
        data_next = up_data;
        if (!up_data.z[CORD_W-1])
        begin
            data_next.x = up_data.x - dx;
            data_next.y = up_data.y + dy;
            data_next.z = up_data.z - a;
        end
        else
        begin
            data_next.x = up_data.x + dx;
            data_next.y = up_data.y - dy;
            data_next.z = up_data.z + a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ----- src/bfl_div_cell.sv -----
`default_nettype none
module bfl_div_cell import bfl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_ready,
    input  wire div_t up_data,
    output logic      down_valid,
    input  wire logic down_ready,
    output div_t      down_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // one restoring step: bring in the next numerator bit
    always_comb
    begin
        logic [DEN_W:0] t;
        logic           qbit;
        t    = {up_data.rem, up_data.num[NUM_W-1]};
        qbit = (t >= {1'b0, up_data.den});
        data_next     = up_data;
        data_next.rem = qbit ? DEN_W'(t - {1'b0, up_data.den}) : DEN_W'(t);
        data_next.num = {up_data.num[NUM_W-2:0], 1'b0};
        data_next.quo = {up_data.quo[NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

    // partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.den != '0) |-> (data_reg.rem < data_reg.den))
        else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

// ----- src/bfl_arith.sv -----
`default_nettype none
module bfl_arith import bfl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [DATA_W-1:0] position_gain,
    input  wire logic [DATA_W-1:0] velocity_gain,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire cord_t             up_data,
    output logic                   down_valid,
    input  wire logic              down_ready,
    output div_t                   down_data
);

    logic  valid_reg [ARITH_STAGES];
    work_t stg_reg   [ARITH_STAGES];
    work_t stg_next  [ARITH_STAGES];
    logic  stg_ready [ARITH_STAGES+1];

    // back-pressure from the far end
    always_comb
    begin
        stg_ready[ARITH_STAGES] = down_ready;
        for (int k = ARITH_STAGES - 1; k >= 0; k--)
        begin
            stg_ready[k] = !valid_reg[k] || stg_ready[k+1];
        end
    end

    assign up_ready = stg_ready[0];

    // stage 0: fold back, round cos/sin, position error, |speed|^2
    always_comb
    begin
        logic signed [CORD_W-1:0] xf;
        logic signed [CORD_W-1:0] yf;
        logic signed [CORD_W-1:0] half;
        work_t w;
        w      = stg_reg[0];
        w.smp  = up_data.smp;
        xf     = up_data.neg ? -up_data.x : up_data.x;
        yf     = up_data.neg ? -up_data.y : up_data.y;
        half   = '0;
        half[CORD_FRAC-FRAC_BITS-1] = 1'b1;
        w.c    = CS_W'((xf + half) >>> (CORD_FRAC - FRAC_BITS));
        w.s    = CS_W'((yf + half) >>> (CORD_FRAC - FRAC_BITS));
        w.ex   = sat32(SAT_W'(up_data.smp.target_x) - SAT_W'(up_data.smp.pos_x));
        w.ey   = sat32(SAT_W'(up_data.smp.target_y) - SAT_W'(up_data.smp.pos_y));
        w.mag  = up_data.smp.speed[DATA_W-1] ? DATA_W'(-up_data.smp.speed)
                                             : DATA_W'(up_data.smp.speed);
        w.zero = (up_data.smp.speed == '0);
        w.mm   = w.mag * w.mag;
        stg_next[0] = w;
    end

    // stage 1: speed times heading, position term, signed speed squared
    always_comb
    begin
        logic [SQ_W-1:0]         qmag;
        logic signed [SAT_W-1:0] qv;
        work_t w;
        w      = stg_reg[0];
        w.mc   = w.smp.speed * w.c;
        w.ms   = w.smp.speed * w.s;
        w.kpex = $signed({1'b0, position_gain}) * w.ex;
        w.kpey = $signed({1'b0, position_gain}) * w.ey;
        qmag   = (w.mm + (SQ_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        qv     = signed'(SAT_W'(qmag));
        if (w.smp.speed[DATA_W-1])
            qv = -qv;
        w.q    = sat32(qv);
        stg_next[1] = w;
    end

    // stage 2: velocity error, drag term products
    always_comb
    begin
        work_t w;
        w     = stg_reg[1];
        w.dvx = sat32(SAT_W'(w.smp.target_vel_x) - rnd_q(SAT_W'(w.mc), FRAC_BITS));
        w.dvy = sat32(SAT_W'(w.smp.target_vel_y) - rnd_q(SAT_W'(w.ms), FRAC_BITS));
        w.qc  = w.q * w.c;
        w.qs  = w.q * w.s;
        stg_next[2] = w;
    end

    // stage 3: velocity term
    always_comb
    begin
        work_t w;
        w     = stg_reg[2];
        w.kdx = $signed({1'b0, velocity_gain}) * w.dvx;
        w.kdy = $signed({1'b0, velocity_gain}) * w.dvy;
        stg_next[3] = w;
    end

    // stage 4: virtual control
    always_comb
    begin
        work_t w;
        w    = stg_reg[3];
        w.vx = sat32(rnd_q(SAT_W'(w.kpex), FRAC_BITS) + rnd_q(SAT_W'(w.kdx), FRAC_BITS)
                     + SAT_W'(w.smp.target_acc_x));
        w.vy = sat32(rnd_q(SAT_W'(w.kpey), FRAC_BITS) + rnd_q(SAT_W'(w.kdy), FRAC_BITS)
                     + SAT_W'(w.smp.target_acc_y));
        stg_next[4] = w;
    end

    // stage 5: add drag compensation
    always_comb
    begin
        work_t w;
        w    = stg_reg[4];
        w.rx = sat32(SAT_W'(w.vx) + rnd_q(SAT_W'(w.qc), FRAC_BITS));
        w.ry = sat32(SAT_W'(w.vy) + rnd_q(SAT_W'(w.qs), FRAC_BITS));
        stg_next[5] = w;
    end

    // stage 6: rotate into the body frame
    always_comb
    begin
        work_t w;
        w     = stg_reg[5];
        w.crx = w.c * w.rx;
        w.sry = w.s * w.ry;
        w.srx = w.s * w.rx;
        w.cry = w.c * w.ry;
        stg_next[6] = w;
    end

    // stage 7: half of the along-track part, dividend with rounding offset
    always_comb
    begin
        logic signed [SAT_W-1:0] p_v;
        logic signed [SAT_W-1:0] pabs;
        work_t w;
        w      = stg_reg[6];
        w.ha   = HA_W'(rnd_q(SAT_W'(w.crx) + SAT_W'(w.sry), FRAC_BITS + 1));
        p_v    = SAT_W'(w.srx) - SAT_W'(w.cry);
        pabs   = p_v[SAT_W-1] ? -p_v : p_v;
        w.num  = NUM_W'(pabs) + NUM_W'(w.mag);
        w.wneg = (p_v[SAT_W-1] != w.smp.speed[DATA_W-1]);
        stg_next[7] = w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ARITH_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= stg_ready[0] ? up_valid : valid_reg[0];
            for (int k = 1; k < ARITH_STAGES; k++)
            begin
                if (stg_ready[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ARITH_STAGES; k++)
        begin
            if (stg_ready[k])
                stg_reg[k] <= stg_next[k];
        end
    end

    // hand over to the divider chain
    assign down_valid     = valid_reg[ARITH_STAGES-1];
    assign down_data.ha   = stg_reg[ARITH_STAGES-1].ha;
    assign down_data.num  = stg_reg[ARITH_STAGES-1].num;
    assign down_data.quo  = '0;
    assign down_data.den  = {stg_reg[ARITH_STAGES-1].mag, 1'b0};
    assign down_data.rem  = '0;
    assign down_data.wneg = stg_reg[ARITH_STAGES-1].wneg;
    assign down_data.zero = stg_reg[ARITH_STAGES-1].zero;

endmodule
`default_nettype wire
